>>> design/u8dv_pkg.sv
// u8dv_pkg: shared types, constants and the lead-byte decode function
// for the UTF-8 stream decoder and validator. No dependencies.
`timescale 1ns / 1ps

package u8dv_pkg;

   // Width of the per-string glyph counter (saturating)
   localparam int COUNT_BITS = 32;
   // Width of the reported glyph total
   localparam int TOTAL_BITS = 32;
   localparam int CP_BITS    = 21;

   // Byte patterns
   localparam logic [7:0] CONT_MASK    = 8'hc0;
   localparam logic [7:0] CONT_MARK    = 8'h80;
   localparam logic [7:0] PAYLOAD_MASK = 8'h3f;
   localparam logic [7:0] LEAD2_MASK   = 8'h1f;
   localparam logic [7:0] LEAD3_MASK   = 8'h0f;
   localparam logic [7:0] LEAD4_MASK   = 8'h07;
   localparam logic [7:0] TERMINATOR   = 8'h00;

   // Glyph lengths; LEN_BAD marks an invalid lead byte
   localparam logic [2:0] LEN_BAD = 3'd0;
   localparam logic [2:0] LEN_1   = 3'd1;
   localparam logic [2:0] LEN_2   = 3'd2;
   localparam logic [2:0] LEN_3   = 3'd3;
   localparam logic [2:0] LEN_4   = 3'd4;

   typedef logic [COUNT_BITS-1:0] count_type;

   // One result item
   typedef struct packed {
      logic                  glyph_ready;
      logic [CP_BITS-1:0]    code_point;
      logic [2:0]            glyph_bytes;
      logic                  string_end;
      logic                  string_valid;
      logic [TOTAL_BITS-1:0] glyph_total;
   } result_type;

   // Handoff from the input register to the decode stage
   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
   } item_type;

   // Glyph length from the top five bits of a lead byte
   function automatic logic [2:0] lead_len(input logic [4:0] top);
      logic [2:0] len;
      case (top) inside
         5'b0????: len = LEN_1;
         5'b110??: len = LEN_2;
         5'b1110?: len = LEN_3;
         5'b11110: len = LEN_4;
         default:  len = LEN_BAD;  // 10xxx continuation, 11111
      endcase
      return len;
   endfunction

endpackage

>>> design/u8dv_req_if.sv
// u8dv_req_if: request channel carrying one string byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface u8dv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

>>> design/u8dv_rsp_if.sv
// u8dv_rsp_if: response channel carrying one decode result.
// Depends on u8dv_pkg for field widths.
`timescale 1ns / 1ps

interface u8dv_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            glyph_ready;
   logic [u8dv_pkg::CP_BITS-1:0]    code_point;
   logic [2:0]                      glyph_bytes;
   logic                            string_end;
   logic                            string_valid;
   logic [u8dv_pkg::TOTAL_BITS-1:0] glyph_total;

   modport source (output valid, output glyph_ready, output code_point, output glyph_bytes,
                   output string_end, output string_valid, output glyph_total,
                   input ready);
   modport sink   (input valid, input glyph_ready, input code_point, input glyph_bytes,
                   input string_end, input string_valid, input glyph_total,
                   output ready);
endinterface

>>> design/u8dv_in_stage.sv
// u8dv_in_stage: input register for incoming string bytes.
// Depends on u8dv_pkg (item_type).
`timescale 1ns / 1ps

module u8dv_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               take,        // decode stage consumes the held byte
   output u8dv_pkg::item_type item
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   // Free when empty or being drained this cycle
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         byte_in  = req_data_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign item.valid     = valid_ff;
   assign item.data_byte = byte_ff;

endmodule

>>> design/u8dv_decode.sv
// u8dv_decode: per-string decode state and single-step UTF-8 decode logic.
// Depends on u8dv_pkg (types, constants, lead_len).
`timescale 1ns / 1ps

module u8dv_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  u8dv_pkg::item_type   item,
   input  logic                 advance,    // result register can load
   output logic                 take,
   output logic                 res_valid,
   output u8dv_pkg::result_type res
);

   logic [1:0]                    rem_ff, rem_in;
   logic [2:0]                    len_ff, len_in;
   logic [u8dv_pkg::CP_BITS-1:0]  acc_ff, acc_in;
   logic                          err_ff, err_in;
   u8dv_pkg::count_type           cnt_ff, cnt_in;

   logic [7:0] b;
   logic [2:0] lead;
   logic       complete;
   logic       has_res;

   assign b    = item.data_byte;
   assign lead = u8dv_pkg::lead_len(b[7:3]);
   assign take = item.valid && advance;

   // One decode step
   always_comb begin
      rem_in   = rem_ff;
      len_in   = len_ff;
      acc_in   = acc_ff;
      err_in   = err_ff;
      cnt_in   = cnt_ff;
      complete = 1'b0;
      has_res  = 1'b0;
      res      = '0;

      if (b == u8dv_pkg::TERMINATOR) begin
         // end of string: report and clear
         has_res          = 1'b1;
         res.string_end   = 1'b1;
         res.string_valid = !err_ff && (rem_ff == 2'd0);
         res.glyph_total  = u8dv_pkg::TOTAL_BITS'(cnt_ff);
         rem_in           = '0;
         len_in           = '0;
         acc_in           = '0;
         err_in           = 1'b0;
         cnt_in           = '0;
      end else if (err_ff) begin
         // skip until terminator
      end else if (rem_ff != 2'd0) begin
         // continuation byte
         if ((b & u8dv_pkg::CONT_MASK) != u8dv_pkg::CONT_MARK) begin
            err_in = 1'b1;
            rem_in = '0;
            len_in = '0;
            acc_in = '0;
         end else begin
            acc_in   = {acc_ff[u8dv_pkg::CP_BITS-7:0], b[5:0]};
            rem_in   = rem_ff - 2'd1;
            complete = (rem_ff == 2'd1);
         end
      end else begin
         // lead byte
         if (lead == u8dv_pkg::LEN_BAD) begin
            err_in = 1'b1;
         end else begin
            len_in = lead;
            rem_in = 2'(lead - 3'd1);
            case (lead)
               u8dv_pkg::LEN_1: acc_in = u8dv_pkg::CP_BITS'(b);
               u8dv_pkg::LEN_2: acc_in = u8dv_pkg::CP_BITS'(b & u8dv_pkg::LEAD2_MASK);
               u8dv_pkg::LEN_3: acc_in = u8dv_pkg::CP_BITS'(b & u8dv_pkg::LEAD3_MASK);
               default:         acc_in = u8dv_pkg::CP_BITS'(b & u8dv_pkg::LEAD4_MASK);
            endcase
            complete = (lead == u8dv_pkg::LEN_1);
         end
      end

      // glyph done: count (saturating) and emit
      if (complete) begin
         if (cnt_ff != '1) begin
            cnt_in = cnt_ff + 1'b1;
         end
         has_res         = 1'b1;
         res.glyph_ready = 1'b1;
         res.code_point  = acc_in;
         res.glyph_bytes = len_in;
         res.glyph_total = u8dv_pkg::TOTAL_BITS'(cnt_in);
         rem_in          = '0;
         len_in          = '0;
         acc_in          = '0;
      end
   end

   assign res_valid = take && has_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         len_ff <= '0;
         acc_ff <= '0;
         err_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (take) begin
         rem_ff <= rem_in;
         len_ff <= len_in;
         acc_ff <= acc_in;
         err_ff <= err_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> design/u8dv_out_stage.sv
// u8dv_out_stage: result register driving the response channel.
// Depends on u8dv_pkg (result_type).
`timescale 1ns / 1ps

module u8dv_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  u8dv_pkg::result_type res,
   output logic                 advance,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output u8dv_pkg::result_type rsp_data
);

   logic                 valid_ff, valid_in;
   u8dv_pkg::result_type data_ff, data_in;

   // Register may load when empty or being emptied
   assign advance = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         valid_in = res_valid;
         data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> design/utf8_stream_decoder_validator_top.sv
// UTF-8 stream decoder and validator: takes one string byte per request and
// returns a response for each completed glyph (code point, length, running count)
// and one at each zero terminator (validity, glyph count). Bytes that start or
// continue a glyph without completing it, and bytes after the first error, give
// no response. The block accepts one byte every cycle unless the response channel
// is stalled; a byte passes an input register and then the decode step into the
// result register. The glyph counter saturates.
// Depends on u8dv_pkg, u8dv_req_if, u8dv_rsp_if and the u8dv_* stage modules.
`timescale 1ns / 1ps

module utf8_stream_decoder_validator_top (
   input  logic       clock,
   input  logic       reset,
   u8dv_req_if.sink   req_if,
   u8dv_rsp_if.source rsp_if
);

   u8dv_pkg::item_type   item;
   u8dv_pkg::result_type res;
   u8dv_pkg::result_type rsp_data;
   logic                 take;
   logic                 advance;
   logic                 res_valid;
   logic                 req_ready;
   logic                 rsp_valid;

   // Input register
   u8dv_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_ready),
      .req_data_byte (req_if.data_byte),
      .take          (take),
      .item          (item)
   );

   // Decode step and string state
   u8dv_decode u_dec (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .advance   (advance),
      .take      (take),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result register
   u8dv_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .rsp_data  (rsp_data)
   );

   assign req_if.ready        = req_ready;
   assign rsp_if.valid        = rsp_valid;
   assign rsp_if.glyph_ready  = rsp_data.glyph_ready;
   assign rsp_if.code_point   = rsp_data.code_point;
   assign rsp_if.glyph_bytes  = rsp_data.glyph_bytes;
   assign rsp_if.string_end   = rsp_data.string_end;
   assign rsp_if.string_valid = rsp_data.string_valid;
   assign rsp_if.glyph_total  = rsp_data.glyph_total;

endmodule

>>> design/u8dv_checker.sv
// u8dv_checker: port-level assertions for the UTF-8 decoder, bound to the top.
// Depends on u8dv_pkg and utf8_stream_decoder_validator_top.
`timescale 1ns / 1ps

module u8dv_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            glyph_ready,
   input logic [u8dv_pkg::CP_BITS-1:0]    code_point,
   input logic [2:0]                      glyph_bytes,
   input logic                            string_end,
   input logic                            string_valid
);

   // A stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Every response is exactly one kind
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (glyph_ready != string_end))
      else $error("response is neither or both glyph and string end");

   // Glyph responses carry a legal length and no validity flag
   a_glyph_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && glyph_ready |->
         (glyph_bytes == 3'd1 || glyph_bytes == 3'd2 || glyph_bytes == 3'd3 ||
          glyph_bytes == 3'd4) && !string_valid)
      else $error("bad glyph response fields");

   // Single-byte glyphs are ASCII; string-end responses carry no glyph
   a_ascii: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && glyph_ready && glyph_bytes == 3'd1 |-> code_point[u8dv_pkg::CP_BITS-1:7] == '0)
      else $error("one-byte glyph above 0x7f");

   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && string_end |-> code_point == '0 && glyph_bytes == 3'd0)
      else $error("string end carries glyph data");

endmodule

bind utf8_stream_decoder_validator_top u8dv_checker u_chk (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .glyph_ready  (rsp_if.glyph_ready),
   .code_point   (rsp_if.code_point),
   .glyph_bytes  (rsp_if.glyph_bytes),
   .string_end   (rsp_if.string_end),
   .string_valid (rsp_if.string_valid)
);
